// ===== hw/rtl/chr420_pkg.sv =====
// ============================================================================
// chr420_pkg
// Shared types and constants of the bilinear 4:2:0 to 4:4:4 chroma upsampler.
// ============================================================================
`default_nettype none

package chr420_pkg;

    localparam int SAMPLE_BITS        = 12;
    localparam int MAX_WIDTH_DEFAULT  = 256;
    localparam int MAX_HEIGHT_DEFAULT = 256;
    localparam int CFG_BITS           = 9;
    localparam int COORD_BITS         = 7;
    localparam int PIXEL_BITS         = 8;
    localparam int FRAC_BITS          = 3;
    localparam int WEIGHT_BITS        = 6;
    localparam int PROD_BITS          = SAMPLE_BITS + WEIGHT_BITS;
    localparam int ACC_BITS           = PROD_BITS + 2;
    localparam int NUM_BANKS          = 4;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CFG_BITS-1:0] FRAME_SIZE_RESET = 9'd256;
    localparam logic [CFG_BITS-1:0] FRAME_SIZE_MIN   = 9'd4;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_INTERP = 1'b1
    } req_type_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        req_type_t               req_type;
        logic [COORD_BITS-1:0]   sample_col;
        logic [COORD_BITS-1:0]   sample_row;
        sample_t                 cb_in;
        sample_t                 cr_in;
        logic [PIXEL_BITS-1:0]   pixel_x;
        logic [PIXEL_BITS-1:0]   pixel_y;
    } req_t;

    typedef struct packed {
        sample_t cb_out;
        sample_t cr_out;
        logic    saturated;
    } rsp_t;

    // Queue entry: a load carries its location and samples, an interpolate
    // carries the top-left neighbour and the four blend weights.
    typedef struct packed {
        logic                    is_load;
        logic [COORD_BITS-1:0]   col;
        logic [COORD_BITS-1:0]   row;
        sample_t                 cb;
        sample_t                 cr;
        weight_t [NUM_BANKS-1:0] wt;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chr420_ram.sv =====
// ============================================================================
// chr420_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module chr420_ram #(
    parameter int WIDTH = 2 * chr420_pkg::SAMPLE_BITS,
    parameter int DEPTH = (chr420_pkg::MAX_WIDTH_DEFAULT / 4)
                        * (chr420_pkg::MAX_HEIGHT_DEFAULT / 4)
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/chr420_front.sv =====
// ============================================================================
// chr420_front
// Frame size registers, request intake and classification: loads are checked
// against storage, interpolates are mapped to a neighbour and four weights.
// ============================================================================
`default_nettype none

module chr420_front #(
    parameter int MAX_WIDTH  = chr420_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = chr420_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_en,
    input  wire chr420_pkg::cfg_index_t             cfg_index,
    input  wire logic [chr420_pkg::CFG_BITS-1:0]    cfg_data,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire chr420_pkg::req_t                   req_data,
    input  wire chr420_pkg::queue_status_t          queue_status,
    output logic                                    push,
    output chr420_pkg::cmd_t                        cmd
);

    localparam int PlaneCols = MAX_WIDTH / 2;
    localparam int PlaneRows = MAX_HEIGHT / 2;

    logic [chr420_pkg::CFG_BITS-1:0] frame_width_reg;
    logic [chr420_pkg::CFG_BITS-1:0] frame_height_reg;

    logic [chr420_pkg::CFG_BITS-1:0]   width_eff;
    logic [chr420_pkg::CFG_BITS-1:0]   height_eff;
    logic [chr420_pkg::COORD_BITS+chr420_pkg::FRAC_BITS-1:0] x_map;
    logic [chr420_pkg::COORD_BITS+chr420_pkg::FRAC_BITS-1:0] y_map;
    logic signed [3:0]                 wx [2];
    logic signed [3:0]                 wy [2];
    logic                              is_interp;
    logic                              load_in_range;

    function automatic logic [chr420_pkg::CFG_BITS-1:0] clamp_size(
        input logic [chr420_pkg::CFG_BITS-1:0] v,
        input int                              hi
    );
        if (v < chr420_pkg::FRAME_SIZE_MIN)
        begin
            return chr420_pkg::FRAME_SIZE_MIN;
        end
        if (int'(v) > hi)
        begin
            return chr420_pkg::CFG_BITS'(hi);
        end
        return v;
    endfunction

    // Clamp the pixel into the frame, halve it, pull the neighbour back so
    // that it and the next one stay inside the half plane; the fraction is
    // left over in half units (0 to 4 with odd frame sizes).
    function automatic logic [chr420_pkg::COORD_BITS+chr420_pkg::FRAC_BITS-1:0] axis_map(
        input logic [chr420_pkg::CFG_BITS-1:0]   size,
        input logic [chr420_pkg::PIXEL_BITS-1:0] p
    );
        logic [7:0]                           half;
        logic [8:0]                           lim;
        logic [7:0]                           q;
        logic [7:0]                           idx;
        logic [chr420_pkg::FRAC_BITS-1:0]     frac;
        half = size[8:1];
        lim  = size - 9'd1;
        q    = ({1'b0, p} > lim) ? lim[7:0] : p;
        idx  = {1'b0, q[7:1]};
        if ({1'b0, idx} + 9'd1 >= {1'b0, half})
        begin
            idx = half - 8'd2;
        end
        frac = chr420_pkg::FRAC_BITS'({1'b0, q} - {idx, 1'b0});
        return {idx[chr420_pkg::COORD_BITS-1:0], frac};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= chr420_pkg::FRAME_SIZE_RESET;
            frame_height_reg <= chr420_pkg::FRAME_SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                chr420_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                chr420_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        width_eff  = clamp_size(frame_width_reg, MAX_WIDTH);
        height_eff = clamp_size(frame_height_reg, MAX_HEIGHT);
        x_map      = axis_map(width_eff, req_data.pixel_x);
        y_map      = axis_map(height_eff, req_data.pixel_y);

        wx[1] = signed'({1'b0, x_map[chr420_pkg::FRAC_BITS-1:0]});
        wx[0] = 4'sd2 - wx[1];
        wy[1] = signed'({1'b0, y_map[chr420_pkg::FRAC_BITS-1:0]});
        wy[0] = 4'sd2 - wy[1];

        is_interp     = (req_data.req_type == chr420_pkg::REQ_INTERP);
        load_in_range = (int'(req_data.sample_col) < PlaneCols)
                     && (int'(req_data.sample_row) < PlaneRows);

        req_ready = !queue_status.full;
        // Drop loads that fall outside storage: accepted, never queued.
        push      = req_valid && req_ready && (is_interp || load_in_range);

        cmd.is_load = !is_interp;
        cmd.col     = is_interp ? x_map[chr420_pkg::FRAC_BITS +: chr420_pkg::COORD_BITS]
                                : req_data.sample_col;
        cmd.row     = is_interp ? y_map[chr420_pkg::FRAC_BITS +: chr420_pkg::COORD_BITS]
                                : req_data.sample_row;
        cmd.cb      = req_data.cb_in;
        cmd.cr      = req_data.cr_in;
        for (int p = 0; p < chr420_pkg::NUM_BANKS; p++)
        begin
            cmd.wt[p] = chr420_pkg::weight_t'(
                chr420_pkg::weight_t'(wy[p / 2]) * chr420_pkg::weight_t'(wx[p % 2]));
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/chr420_queue.sv =====
// ============================================================================
// chr420_queue
// Short command queue between the front and the back end.
// ============================================================================
`default_nettype none

module chr420_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire chr420_pkg::cmd_t          cmd_in,
    input  wire logic                      pop,
    output chr420_pkg::cmd_t               cmd_out,
    output chr420_pkg::queue_status_t      status
);

    localparam int PtrBits = chr420_pkg::QUEUE_DEPTH > 1 ? $clog2(chr420_pkg::QUEUE_DEPTH) : 1;
    localparam int CntBits = $clog2(chr420_pkg::QUEUE_DEPTH + 1);

    chr420_pkg::cmd_t   entry_reg [chr420_pkg::QUEUE_DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [CntBits-1:0] count_reg;
    logic [PtrBits-1:0] wr_ptr_next;
    logic [PtrBits-1:0] rd_ptr_next;
    logic [CntBits-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(chr420_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + PtrBits'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(chr420_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + PtrBits'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntBits'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntBits'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_out = entry_reg[rd_ptr_reg];
    assign status  = '{empty: (count_reg == '0),
                       full:  (count_reg == CntBits'(chr420_pkg::QUEUE_DEPTH))};

endmodule

`default_nettype wire

// ===== hw/rtl/chr420_back.sv =====
// ============================================================================
// chr420_back
// Four parity-interleaved chroma banks and the blend pipeline: bank read,
// weighted products, then sum, rounding and saturation into the result.
// ============================================================================
`default_nettype none

module chr420_back #(
    parameter int MAX_WIDTH  = chr420_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = chr420_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chr420_pkg::cmd_t              head,
    input  wire chr420_pkg::queue_status_t     queue_status,
    output logic                               pop,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output chr420_pkg::rsp_t                   rsp_data
);

    localparam int PlaneCols = MAX_WIDTH / 2;
    localparam int PlaneRows = MAX_HEIGHT / 2;
    localparam int BankCols  = (PlaneCols + 1) / 2;
    localparam int BankRows  = (PlaneRows + 1) / 2;
    localparam int ColBits   = BankCols > 1 ? $clog2(BankCols) : 1;
    localparam int RowBits   = BankRows > 1 ? $clog2(BankRows) : 1;
    localparam int AddrBits  = ColBits + RowBits;
    localparam int BankDepth = 1 << AddrBits;
    localparam int SB        = chr420_pkg::SAMPLE_BITS;
    localparam int NB        = chr420_pkg::NUM_BANKS;

    logic                                advance;
    logic                                do_read;
    logic [chr420_pkg::COORD_BITS-2:0]   col_half;
    logic [chr420_pkg::COORD_BITS-2:0]   row_half;
    logic [AddrBits-1:0]                 wr_addr;
    logic [1:0]                          wr_bank;
    logic [AddrBits-1:0]                 rd_addr [NB];
    logic [2*SB-1:0]                     rd_data [NB];

    logic                                s1_valid_reg;
    chr420_pkg::weight_t                 s1_wt_reg [NB];
    logic [1:0]                          s1_par_reg;

    logic                                s2_valid_reg;
    logic signed [chr420_pkg::PROD_BITS-1:0] prod_cb_reg [NB];
    logic signed [chr420_pkg::PROD_BITS-1:0] prod_cr_reg [NB];
    logic signed [chr420_pkg::PROD_BITS-1:0] prod_cb_next [NB];
    logic signed [chr420_pkg::PROD_BITS-1:0] prod_cr_next [NB];

    logic signed [chr420_pkg::ACC_BITS-1:0] acc_cb;
    logic signed [chr420_pkg::ACC_BITS-1:0] acc_cr;
    logic [SB:0]                         res_cb;
    logic [SB:0]                         res_cr;

    logic                                rsp_valid_reg;
    chr420_pkg::rsp_t                    rsp_reg;
    chr420_pkg::rsp_t                    rsp_next;

    // Quarter-unit sum to sample: floor((acc + 2) / 4), then clip.
    // Returns the clip flag above the sample.
    function automatic logic [SB:0] round_sat(
        input logic signed [chr420_pkg::ACC_BITS-1:0] acc
    );
        logic signed [chr420_pkg::ACC_BITS-1:0] q;
        q = (acc + chr420_pkg::ACC_BITS'(2)) >>> 2;
        if (q > chr420_pkg::ACC_BITS'(chr420_pkg::SAMPLE_MAX))
        begin
            return {1'b1, chr420_pkg::SAMPLE_MAX};
        end
        if (q < chr420_pkg::ACC_BITS'(chr420_pkg::SAMPLE_MIN))
        begin
            return {1'b1, chr420_pkg::SAMPLE_MIN};
        end
        return {1'b0, q[SB-1:0]};
    endfunction

    // Loads need no pipeline slot; interpolates move only with the pipeline.
    assign advance  = !rsp_valid_reg || rsp_ready;
    assign pop      = !queue_status.empty && (head.is_load || advance);
    assign do_read  = pop && !head.is_load;
    assign col_half = head.col[chr420_pkg::COORD_BITS-1:1];
    assign row_half = head.row[chr420_pkg::COORD_BITS-1:1];
    assign wr_addr  = {RowBits'(row_half), ColBits'(col_half)};
    assign wr_bank  = {head.row[0], head.col[0]};

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        localparam logic [1:0] BankId = 2'(b);

        logic [chr420_pkg::COORD_BITS-1:0] col_addr;
        logic [chr420_pkg::COORD_BITS-1:0] row_addr;

        // Bank holds the even or odd member of the neighbour pair; step the
        // half index when the pair starts on the other parity.
        assign col_addr = chr420_pkg::COORD_BITS'(col_half)
                        + chr420_pkg::COORD_BITS'(head.col[0] & ~BankId[0]);
        assign row_addr = chr420_pkg::COORD_BITS'(row_half)
                        + chr420_pkg::COORD_BITS'(head.row[0] & ~BankId[1]);
        assign rd_addr[b] = {RowBits'(row_addr), ColBits'(col_addr)};

        chr420_ram #(
            .WIDTH (2 * SB),
            .DEPTH (BankDepth)
        ) u_ram (
            .clk     (clk),
            .wr_en   (pop && head.is_load && (wr_bank == BankId)),
            .wr_addr (wr_addr),
            .wr_data ({head.cb, head.cr}),
            .rd_en   (do_read),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b])
        );
    end

    always_comb
    begin
        for (int p = 0; p < NB; p++)
        begin
            prod_cb_next[p] = chr420_pkg::PROD_BITS'(s1_wt_reg[p])
                * chr420_pkg::PROD_BITS'(chr420_pkg::sample_t'(
                    rd_data[2'(p) ^ s1_par_reg][2*SB-1:SB]));
            prod_cr_next[p] = chr420_pkg::PROD_BITS'(s1_wt_reg[p])
                * chr420_pkg::PROD_BITS'(chr420_pkg::sample_t'(
                    rd_data[2'(p) ^ s1_par_reg][SB-1:0]));
        end
    end

    always_comb
    begin
        acc_cb = '0;
        acc_cr = '0;
        for (int p = 0; p < NB; p++)
        begin
            acc_cb = acc_cb + chr420_pkg::ACC_BITS'(prod_cb_reg[p]);
            acc_cr = acc_cr + chr420_pkg::ACC_BITS'(prod_cr_reg[p]);
        end
        res_cb             = round_sat(acc_cb);
        res_cr             = round_sat(acc_cr);
        rsp_next.cb_out    = res_cb[SB-1:0];
        rsp_next.cr_out    = res_cr[SB-1:0];
        rsp_next.saturated = res_cb[SB] || res_cr[SB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= do_read;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            for (int p = 0; p < NB; p++)
            begin
                s1_wt_reg[p] <= head.wt[p];
            end
            s1_par_reg <= {head.row[0], head.col[0]};
        end
        if (advance)
        begin
            for (int p = 0; p < NB; p++)
            begin
                prod_cb_reg[p] <= prod_cb_next[p];
                prod_cr_reg[p] <= prod_cr_next[p];
            end
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/chroma_420_to_444_bilinear_top.sv =====
// ============================================================================
// chroma_420_to_444_bilinear_top
// Bilinear 4:2:0 to 4:4:4 chroma upsampler with on-chip half-resolution plane.
// ============================================================================
// A load request stores one Cb/Cr pair of the half-resolution plane; an
// interpolate request returns the blended pair for one full-resolution pixel,
// rounded half up and clipped to the signed sample range with a flag. Requests
// enter a two-entry command queue and sustain one per cycle while not full.
// The plane lives in four banks split by row and column parity, so the four
// neighbours of a pixel come out of one bank read; an interpolate result is
// registered via queue entry, bank read, weighted products and sum and clip;
// a load reaches the banks from the queue head, in request order. Loads
// outside storage are taken and dropped. Plane entries are undefined until
// loaded. Write frame_width and frame_height only while the block is idle.
`default_nettype none

module chroma_420_to_444_bilinear_top #(
    parameter int MAX_WIDTH  = chr420_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = chr420_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire chr420_pkg::cfg_index_t          cfg_index,
    input  wire logic [chr420_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire chr420_pkg::req_t                req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output chr420_pkg::rsp_t                     rsp_data
);

    chr420_pkg::queue_status_t queue_status;
    chr420_pkg::cmd_t          push_cmd;
    chr420_pkg::cmd_t          head_cmd;
    logic                      push;
    logic                      pop;

    chr420_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_data     (req_data),
        .queue_status (queue_status),
        .push         (push),
        .cmd          (push_cmd)
    );

    chr420_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .status  (queue_status)
    );

    chr420_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_cmd),
        .queue_status (queue_status),
        .pop          (pop),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_data     (rsp_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/chr420_checker.sv =====
// ============================================================================
// chr420_checker
// Port-level checks of the chroma upsampler, bound to the top level.
// ============================================================================
`default_nettype none

module chr420_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire chr420_pkg::rsp_t rsp_data
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result dropped or changed");

    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.saturated |->
            (rsp_data.cb_out == chr420_pkg::SAMPLE_MAX)
            || (rsp_data.cb_out == chr420_pkg::SAMPLE_MIN)
            || (rsp_data.cr_out == chr420_pkg::SAMPLE_MAX)
            || (rsp_data.cr_out == chr420_pkg::SAMPLE_MIN))
        else $error("saturation flag without a clipped sample");

    a_full_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && req_ready))
        else $error("request side stalled without a transfer");

endmodule

bind chroma_420_to_444_bilinear_top chr420_checker u_checker (.*);

`default_nettype wire

// ===== tb/chr420_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chr420_tb_pkg
// Expected-pixel bookkeeping for the chroma upsampler testbench: a mirror of
// the half-resolution plane and frame registers, and a queue of expected
// interpolated pixels checked in order against the block's results.
// ============================================================================

package chr420_tb_pkg;

    import chr420_pkg::*;

    localparam int PLANE_COLS = MAX_WIDTH_DEFAULT / 2;
    localparam int PLANE_ROWS = MAX_HEIGHT_DEFAULT / 2;

    class chroma_blend_scoreboard;

        sample_t             cb_plane [PLANE_COLS*PLANE_ROWS];
        sample_t             cr_plane [PLANE_COLS*PLANE_ROWS];
        logic [CFG_BITS-1:0] frame_w;
        logic [CFG_BITS-1:0] frame_h;
        rsp_t                pending_pixels [$];
        int                  errors;
        int                  loads;
        int                  pixels;
        int                  clipped;

        function new();
            foreach (cb_plane[i])
            begin
                cb_plane[i] = '0;
                cr_plane[i] = '0;
            end
            frame_w = FRAME_SIZE_RESET;
            frame_h = FRAME_SIZE_RESET;
            errors  = 0;
            loads   = 0;
            pixels  = 0;
            clipped = 0;
        endfunction

        function void set_frame(cfg_index_t idx, logic [CFG_BITS-1:0] value);
            if (idx == REG_FRAME_WIDTH)
                frame_w = value;
            else
                frame_h = value;
        endfunction

        function int eff_width();
            if (frame_w < FRAME_SIZE_MIN)
                return int'(FRAME_SIZE_MIN);
            if (frame_w > MAX_WIDTH_DEFAULT)
                return MAX_WIDTH_DEFAULT;
            return int'(frame_w);
        endfunction

        function int eff_height();
            if (frame_h < FRAME_SIZE_MIN)
                return int'(FRAME_SIZE_MIN);
            if (frame_h > MAX_HEIGHT_DEFAULT)
                return MAX_HEIGHT_DEFAULT;
            return int'(frame_h);
        endfunction

        // Top-left neighbour and fractions in half-pixel units (0..4).
        function void locate(input logic [PIXEL_BITS-1:0] px,
                             input logic [PIXEL_BITS-1:0] py,
                             output int col0, output int row0,
                             output int tx, output int ty);
            int w;
            int h;
            int x;
            int y;
            w = eff_width();
            h = eff_height();
            x = (int'(px) > w - 1) ? w - 1 : int'(px);
            y = (int'(py) > h - 1) ? h - 1 : int'(py);
            col0 = x / 2;
            row0 = y / 2;
            // clamp so the right and bottom edges extrapolate
            if (col0 + 1 >= w / 2)
                col0 = w / 2 - 2;
            if (row0 + 1 >= h / 2)
                row0 = h / 2 - 2;
            tx = x - 2 * col0;
            ty = y - 2 * row0;
        endfunction

        function sample_t blend_channel(int s00, int s01, int s10, int s11,
                                        int tx, int ty, inout logic clip);
            int acc;
            acc = (2 - tx) * (2 - ty) * s00 + tx * (2 - ty) * s01
                + (2 - tx) * ty * s10 + tx * ty * s11;
            // quarter units: round half up
            acc = (acc + 2) >>> 2;
            if (acc > int'(SAMPLE_MAX))
            begin
                clip = 1'b1;
                return SAMPLE_MAX;
            end
            if (acc < int'(SAMPLE_MIN))
            begin
                clip = 1'b1;
                return SAMPLE_MIN;
            end
            return sample_t'(acc);
        endfunction

        function void note_request(req_t r);
            int   idx;
            int   col0;
            int   row0;
            int   tx;
            int   ty;
            logic clip;
            rsp_t px_out;
            if (r.req_type == REQ_LOAD)
            begin
                idx = int'(r.sample_row) * PLANE_COLS + int'(r.sample_col);
                cb_plane[idx] = r.cb_in;
                cr_plane[idx] = r.cr_in;
                loads++;
                return;
            end
            locate(r.pixel_x, r.pixel_y, col0, row0, tx, ty);
            idx  = row0 * PLANE_COLS + col0;
            clip = 1'b0;
            px_out.cb_out = blend_channel(cb_plane[idx], cb_plane[idx+1],
                                          cb_plane[idx+PLANE_COLS],
                                          cb_plane[idx+PLANE_COLS+1], tx, ty, clip);
            px_out.cr_out = blend_channel(cr_plane[idx], cr_plane[idx+1],
                                          cr_plane[idx+PLANE_COLS],
                                          cr_plane[idx+PLANE_COLS+1], tx, ty, clip);
            px_out.saturated = clip;
            pending_pixels.push_back(px_out);
            pixels++;
            if (clip)
                clipped++;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_pixel(rsp_t got);
            rsp_t want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: cb %0d cr %0d sat %0b",
                                          got.cb_out, got.cr_out, got.saturated));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.cb_out !== want.cb_out)
                report_mismatch($sformatf("cb_out %0d, want %0d", got.cb_out, want.cb_out));
            if (got.cr_out !== want.cr_out)
                report_mismatch($sformatf("cr_out %0d, want %0d", got.cr_out, want.cr_out));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated %0b, want %0b",
                                          got.saturated, want.saturated));
        endtask

    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench of the bilinear 4:2:0 to 4:4:4 chroma upsampler.
// ============================================================================
// Loads plane entries and interpolates pixels across a series of frame sizes,
// including sizes below the minimum, above the maximum and odd ones. Every
// interpolate is preceded by loads of any neighbour not yet written. Requests
// come in random bursts, the result side stalls on its own pattern, and
// results are compared in order against a mirror of the plane.

module tb;

    import chr420_pkg::*;
    import chr420_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 9;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_RARE_STALL,
        RX_MOSTLY_STALLED
    } rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    cfg_index_t          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic                req_valid;
    logic                req_ready;
    req_t                req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp_data;

    chroma_blend_scoreboard chroma_sb;
    bit                     loaded [PLANE_COLS*PLANE_ROWS];
    int                     burst_left;
    bit                     gaps_on;
    bit                     hold_rsp;
    int                     items_sent;

    chroma_420_to_444_bilinear_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_data     (rsp_data)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Note every transfer on both channels.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                chroma_sb.note_request(req_data);
            if (rsp_valid && rsp_ready)
                chroma_sb.check_pixel(rsp_data);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL chroma_420_to_444_bilinear_top");
        $finish;
    end

    initial
    begin : result_side
        rx_mode_t mode;
        int       left;
        mode      = RX_OPEN;
        left      = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    RX_OPEN:       rsp_ready <= 1'b1;
                    RX_COIN:       rsp_ready <= 1'($urandom_range(0, 1));
                    RX_RARE_STALL: rsp_ready <= ($urandom_range(0, 7) != 0);
                    default:       rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return sample_t'(int'($urandom_range(0, 31)) - 16);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic req_t make_load(int col, int row, sample_t cb, sample_t cr);
        logic [63:0] noise;
        req_t        r;
        noise        = {$urandom, $urandom};
        r            = noise[$bits(req_t)-1:0];
        r.req_type   = REQ_LOAD;
        r.sample_col = COORD_BITS'(col);
        r.sample_row = COORD_BITS'(row);
        r.cb_in      = cb;
        r.cr_in      = cr;
        return r;
    endfunction

    function automatic req_t make_interp(logic [PIXEL_BITS-1:0] px,
                                         logic [PIXEL_BITS-1:0] py);
        logic [63:0] noise;
        req_t        r;
        noise      = {$urandom, $urandom};
        r          = noise[$bits(req_t)-1:0];
        r.req_type = REQ_INTERP;
        r.pixel_x  = px;
        r.pixel_y  = py;
        return r;
    endfunction

    // Mostly inside the frame, often on the last two, sometimes anywhere.
    function automatic logic [PIXEL_BITS-1:0] pick_coord(int size);
        case ($urandom_range(0, 5))
            0:       return PIXEL_BITS'($urandom_range(0, 255));
            1:       return PIXEL_BITS'(size - 1 - int'($urandom_range(0, 1)));
            default: return PIXEL_BITS'($urandom_range(0, size - 1));
        endcase
    endfunction

    task automatic send(req_t r);
        if (burst_left == 0)
        begin
            if (gaps_on && $urandom_range(0, 3) != 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (r.req_type == REQ_LOAD)
            loaded[int'(r.sample_row) * PLANE_COLS + int'(r.sample_col)] = 1'b1;
        req_data  <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Load any neighbour not yet written, then ask for the pixel.
    task automatic interp(logic [PIXEL_BITS-1:0] px, logic [PIXEL_BITS-1:0] py);
        int col0;
        int row0;
        int tx;
        int ty;
        chroma_sb.locate(px, py, col0, row0, tx, ty);
        for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
                if (!loaded[(row0 + dr) * PLANE_COLS + col0 + dc])
                    send(make_load(col0 + dc, row0 + dr, rand_sample(), rand_sample()));
        send(make_interp(px, py));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (chroma_sb.pending_pixels.size() != 0 || hold_rsp)
            @(negedge clk);
        // let trailing loads reach the plane
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frame(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_FRAME_WIDTH;
        cfg_data     <= w;
        chroma_sb.set_frame(REG_FRAME_WIDTH, w);
        @(negedge clk);
        cfg_index    <= REG_FRAME_HEIGHT;
        cfg_data     <= h;
        chroma_sb.set_frame(REG_FRAME_HEIGHT, h);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(int count, bit with_hold);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 2)
                hold_rsp = 1'b1;
            if ($urandom_range(0, 6) == 0)
                send(make_load($urandom_range(0, PLANE_COLS - 1),
                               $urandom_range(0, PLANE_ROWS - 1),
                               rand_sample(), rand_sample()));
            else
                interp(pick_coord(chroma_sb.eff_width()),
                       pick_coord(chroma_sb.eff_height()));
        end
    endtask

    initial
    begin : stimulus
        chroma_sb    = new();
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        req_valid    = 1'b0;
        req_data     = '0;
        burst_left   = 0;
        gaps_on      = 1'b0;
        hold_rsp     = 1'b0;
        items_sent   = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset frame size, corner entries mostly at the sample extremes.
        send(make_load(0, 0, SAMPLE_MAX, SAMPLE_MIN));
        send(make_load(1, 0, SAMPLE_MIN, SAMPLE_MAX));
        send(make_load(0, 1, '0, sample_t'(1)));
        send(make_load(1, 1, sample_t'(-1), SAMPLE_MAX));
        send(make_load(PLANE_COLS - 2, PLANE_ROWS - 2, SAMPLE_MIN, SAMPLE_MIN));
        send(make_load(PLANE_COLS - 1, PLANE_ROWS - 2, SAMPLE_MAX, SAMPLE_MAX));
        send(make_load(PLANE_COLS - 2, PLANE_ROWS - 1, SAMPLE_MAX, SAMPLE_MAX));
        send(make_load(PLANE_COLS - 1, PLANE_ROWS - 1, SAMPLE_MIN, SAMPLE_MIN));
        interp(8'd0, 8'd0);
        interp(8'd1, 8'd1);
        interp(8'd1, 8'd0);
        interp(8'd0, 8'd1);
        // extrapolated corner, clips
        interp(8'd255, 8'd255);
        interp(8'd254, 8'd254);
        interp(8'd253, 8'd255);
        interp(8'd255, 8'd0);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       ;
                1:       write_frame(9'd4, 9'd4);
                2:       write_frame(9'd5, 9'd7);
                3:       write_frame(9'd0, 9'd3);
                4:       write_frame(9'd511, 9'd300);
                5:       write_frame(9'd256, 9'd4);
                6:       write_frame(9'd9, 9'd255);
                default: write_frame(CFG_BITS'($urandom_range(4, 40)),
                                     CFG_BITS'($urandom_range(4, 40)));
            endcase
            gaps_on = (phase % 3 != 2);
            run_random(ITEMS_PER_PHASE, phase == 1 || phase == 6);
            // pause until every pending pixel is back
            drain();
        end

        $display("Ran %0d transfers: %0d loads, %0d pixels (%0d clipped), %0d frame sizes.",
                 items_sent, chroma_sb.loads, chroma_sb.pixels, chroma_sb.clipped,
                 NUM_PHASES);
        $display("Mismatches: %0d", chroma_sb.errors);
        if (chroma_sb.errors == 0)
            $display("PASS chroma_420_to_444_bilinear_top");
        else
            $display("FAIL chroma_420_to_444_bilinear_top");
        $finish;
    end

endmodule
